>>> rtl/core/ecsq_pkg.sv
// Shared constants and codes for the ECN sojourn marking queue.
package ecsq_pkg;

    // Default physical queue depth in descriptors.
    localparam int QueueDepthDefault = 1024;

    // Fixed field widths.
    localparam int TimeW   = 48;
    localparam int RegW    = 24;
    localparam int BytesW  = 16;
    localparam int HandleW = 16;
    localparam int EcnW    = 2;
    localparam int DescW   = HandleW + BytesW + EcnW;
    localparam int MaxPktW = 11;
    localparam int MarkW   = 16;
    localparam int CfgIdxW = 3;

    // Result status codes.
    localparam logic [1:0] StatusAccepted  = 2'd0;
    localparam logic [1:0] StatusDropped   = 2'd1;
    localparam logic [1:0] StatusDelivered = 2'd2;
    localparam logic [1:0] StatusEmpty     = 2'd3;

    // Commands.
    localparam logic CmdEnqueue = 1'b0;
    localparam logic CmdDequeue = 1'b1;

    // ECN codepoints.
    localparam logic [1:0] EcnEct1 = 2'd1;
    localparam logic [1:0] EcnCe   = 2'd3;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CfgLimitByPackets = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgMaxPackets     = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgMaxBytes       = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgInstThreshold  = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgInterval       = 3'd4;
    localparam logic [CfgIdxW-1:0] CfgTarget         = 3'd5;

    // Configuration reset values.
    localparam logic [MaxPktW-1:0] RstMaxPackets    = 11'd100;
    localparam logic [RegW-1:0]    RstMaxBytes      = 24'd150000;
    localparam logic [RegW-1:0]    RstInstThreshold = 24'd20000;
    localparam logic [RegW-1:0]    RstInterval      = 24'd100000;
    localparam logic [RegW-1:0]    RstTarget        = 24'd10000;

endpackage

>>> rtl/core/ecn_sojourn_marking_queue_unit.sv
// Top level of the ECN sojourn marking queue.
//
// Input channel (i_in_valid / o_in_stall) carries one command word: an
// enqueue with time, size, codepoint and handle, or a dequeue with time.
// Every command gives exactly one result word on the output channel
// (o_out_valid / i_out_stall): accepted, dropped, delivered or empty.
// Descriptors and arrival times live in two RAMs with registered reads.
// Commands are handled one at a time. An enqueue or an empty dequeue goes
// from the idle state straight to the push state. A delivered dequeue
// passes through the read and evaluate states, and when a persistent mark
// needs a new spacing, through a bit-serial reciprocal square root (skipped
// when the new count is at most one), a multiply and an add. The push state
// moves the staged result into the output register once that is free.
// The next command is taken only after that move, so while a stalled
// receiver holds the previous result the staged one waits in the push
// state; a stalled result waits in the output register unchanged.
// Synchronous reset empties the queue, clears the marking state and loads
// the default configuration. Configuration writes are always ready.
module ecn_sojourn_marking_queue_unit #(
    parameter int QUEUE_DEPTH = ecsq_pkg::QueueDepthDefault
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input channel.
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_command,
    input  logic [ecsq_pkg::TimeW-1:0]     i_now_ns,
    input  logic [ecsq_pkg::BytesW-1:0]    i_packet_bytes,
    input  logic [ecsq_pkg::EcnW-1:0]      i_ecn_in,
    input  logic [ecsq_pkg::HandleW-1:0]   i_packet_handle,
    // Output channel.
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [1:0]                     o_status,
    output logic [ecsq_pkg::HandleW-1:0]   o_handle_out,
    output logic [ecsq_pkg::BytesW-1:0]    o_bytes_out,
    output logic [ecsq_pkg::EcnW-1:0]      o_ecn_out,
    output logic [ecsq_pkg::TimeW-1:0]     o_sojourn_ns,
    output logic                           o_instant_mark,
    output logic                           o_persistent_mark,
    output logic                           o_ce_applied,
    // Configuration write channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ecsq_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [ecsq_pkg::RegW-1:0]      i_cfg_data
);

    localparam int PtrW  = $clog2(QUEUE_DEPTH);
    localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
    localparam int ByteW = ecsq_pkg::BytesW + CntW;
    localparam int CmpW  = ((ByteW > ecsq_pkg::RegW) ? ByteW : ecsq_pkg::RegW) + 1;
    localparam int TW    = ecsq_pkg::TimeW;
    localparam int MW    = ecsq_pkg::MarkW;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EVAL, S_SQRT, S_MUL, S_ADD, S_PUSH
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic                            r_limit_by_packets;
    logic [ecsq_pkg::MaxPktW-1:0]    r_max_packets;
    logic [ecsq_pkg::RegW-1:0]       r_max_bytes;
    logic [ecsq_pkg::RegW-1:0]       r_inst_thr;
    logic [ecsq_pkg::RegW-1:0]       r_interval;
    logic [ecsq_pkg::RegW-1:0]       r_target;

    // Queue bookkeeping.
    logic [PtrW-1:0]  r_head;
    logic [PtrW-1:0]  r_tail;
    logic [CntW-1:0]  r_pkt_cnt;
    logic [ByteW-1:0] r_byte_cnt;

    // Persistent marking state.
    logic [TW-1:0]    r_first_above;
    logic             r_active;
    logic [TW-1:0]    r_next_mark;
    logic [MW-1:0]    r_mark_cnt;

    // Work registers for the command in flight.
    logic [TW-1:0]    r_now;
    logic [TW-1:0]    r_sojourn;
    logic [MW:0]      r_root;
    logic [40:0]      r_prod;
    logic             r_sq_start;

    // Staged result.
    logic [1:0]                   r_res_status;
    logic [ecsq_pkg::HandleW-1:0] r_res_handle;
    logic [ecsq_pkg::BytesW-1:0]  r_res_bytes;
    logic [ecsq_pkg::EcnW-1:0]    r_res_ecn;
    logic                         r_res_inst;
    logic                         r_res_pers;

    // Output register.
    logic                         r_out_valid;
    logic [1:0]                   r_status;
    logic [ecsq_pkg::HandleW-1:0] r_handle_out;
    logic [ecsq_pkg::BytesW-1:0]  r_bytes_out;
    logic [ecsq_pkg::EcnW-1:0]    r_ecn_out;
    logic [TW-1:0]                r_sojourn_out;
    logic                         r_inst_out;
    logic                         r_pers_out;
    logic                         r_ce_out;

    logic                         in_accept;
    logic                         out_free;
    logic                         drop;
    logic                         enq_ok;
    logic                         deq_read;
    logic [TW-1:0]                arr_rdata;
    logic [ecsq_pkg::DescW-1:0]   desc_rdata;
    logic [ecsq_pkg::BytesW-1:0]  rd_bytes;
    logic                         sq_done;
    logic [MW-1:0]                sq_root;
    logic [TW-1:0]                e_sum_int;
    logic                         e_below;
    logic [TW-1:0]                e_fa;
    logic                         e_ok;
    logic [MW-1:0]                e_cnt_inc;
    logic                         ce;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    // Tail-drop check against physical depth and the configured limit.
    always_comb begin
        drop = (r_pkt_cnt == CntW'(QUEUE_DEPTH));
        if (r_limit_by_packets) begin
            if (18'(r_pkt_cnt) + 18'd1 > 18'(r_max_packets)) begin
                drop = 1'b1;
            end
        end else begin
            if (CmpW'(r_byte_cnt) + CmpW'(i_packet_bytes) > CmpW'(r_max_bytes)) begin
                drop = 1'b1;
            end
        end
    end

    assign enq_ok   = in_accept && (i_command == ecsq_pkg::CmdEnqueue) && !drop;
    assign deq_read = in_accept && (i_command == ecsq_pkg::CmdDequeue) && (r_pkt_cnt != '0);

    // Descriptor and arrival time stores.
    ecsq_ram #(.WIDTH(TW), .DEPTH(QUEUE_DEPTH)) u_arrival_ram (
        .i_clk   (i_clk),
        .i_we    (enq_ok),
        .i_waddr (r_tail),
        .i_wdata (i_now_ns),
        .i_re    (deq_read),
        .i_raddr (r_head),
        .o_rdata (arr_rdata)
    );

    ecsq_ram #(.WIDTH(ecsq_pkg::DescW), .DEPTH(QUEUE_DEPTH)) u_desc_ram (
        .i_clk   (i_clk),
        .i_we    (enq_ok),
        .i_waddr (r_tail),
        .i_wdata ({i_packet_handle, i_packet_bytes, i_ecn_in}),
        .i_re    (deq_read),
        .i_raddr (r_head),
        .o_rdata (desc_rdata)
    );

    assign rd_bytes = desc_rdata[ecsq_pkg::BytesW+1:2];

    // Reciprocal square root of the mark counter.
    ecsq_rsqrt u_rsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sq_start),
        .i_count (r_mark_cnt),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // First-above tracking and the persistent condition.
    always_comb begin
        e_sum_int = r_now + TW'(r_interval);
        e_below   = r_sojourn < TW'(r_target);
        if (e_below) begin
            e_fa = '0;
            e_ok = 1'b0;
        end else if (r_first_above == '0) begin
            e_fa = e_sum_int;
            e_ok = 1'b0;
        end else begin
            e_fa = r_first_above;
            e_ok = r_now > r_first_above;
        end
        e_cnt_inc = (r_mark_cnt == {MW{1'b1}}) ? r_mark_cnt : r_mark_cnt + MW'(1);
    end

    // Marking rewrites ECT(1) to CE only.
    assign ce = (r_res_inst || r_res_pers) && (r_res_ecn == ecsq_pkg::EcnEct1);

    // Sequencer, queue state, configuration and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state            <= S_IDLE;
            r_out_valid        <= 1'b0;
            r_sq_start         <= 1'b0;
            r_head             <= '0;
            r_tail             <= '0;
            r_pkt_cnt          <= '0;
            r_byte_cnt         <= '0;
            r_first_above      <= '0;
            r_active           <= 1'b0;
            r_next_mark        <= '0;
            r_mark_cnt         <= '0;
            r_limit_by_packets <= 1'b0;
            r_max_packets      <= ecsq_pkg::RstMaxPackets;
            r_max_bytes        <= ecsq_pkg::RstMaxBytes;
            r_inst_thr         <= ecsq_pkg::RstInstThreshold;
            r_interval         <= ecsq_pkg::RstInterval;
            r_target           <= ecsq_pkg::RstTarget;
        end else begin
            r_sq_start <= 1'b0;

            // Configuration writes.
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ecsq_pkg::CfgLimitByPackets: r_limit_by_packets <= i_cfg_data[0];
                    ecsq_pkg::CfgMaxPackets:     r_max_packets <= i_cfg_data[ecsq_pkg::MaxPktW-1:0];
                    ecsq_pkg::CfgMaxBytes:       r_max_bytes   <= i_cfg_data;
                    ecsq_pkg::CfgInstThreshold:  r_inst_thr    <= i_cfg_data;
                    ecsq_pkg::CfgInterval:       r_interval    <= i_cfg_data;
                    ecsq_pkg::CfgTarget:         r_target      <= i_cfg_data;
                    default: ;
                endcase
            end

            // The receiver took the held word.
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_now        <= i_now_ns;
                        r_res_handle <= '0;
                        r_res_bytes  <= '0;
                        r_res_ecn    <= '0;
                        r_sojourn    <= '0;
                        r_res_inst   <= 1'b0;
                        r_res_pers   <= 1'b0;
                        if (i_command == ecsq_pkg::CmdEnqueue) begin
                            r_state <= S_PUSH;
                            if (drop) begin
                                r_res_status <= ecsq_pkg::StatusDropped;
                            end else begin
                                r_res_status <= ecsq_pkg::StatusAccepted;
                                r_tail <= (r_tail == PtrW'(QUEUE_DEPTH - 1)) ? '0
                                          : r_tail + PtrW'(1);
                                r_pkt_cnt  <= r_pkt_cnt + CntW'(1);
                                r_byte_cnt <= r_byte_cnt + ByteW'(i_packet_bytes);
                            end
                        end else if (r_pkt_cnt == '0) begin
                            r_res_status <= ecsq_pkg::StatusEmpty;
                            r_state      <= S_PUSH;
                        end else begin
                            r_res_status <= ecsq_pkg::StatusDelivered;
                            r_head <= (r_head == PtrW'(QUEUE_DEPTH - 1)) ? '0
                                      : r_head + PtrW'(1);
                            r_pkt_cnt <= r_pkt_cnt - CntW'(1);
                            r_state   <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    // Head entry is now on the RAM outputs.
                    r_sojourn    <= (r_now >= arr_rdata) ? r_now - arr_rdata : '0;
                    r_res_handle <= desc_rdata[ecsq_pkg::DescW-1:ecsq_pkg::BytesW+2];
                    r_res_bytes  <= rd_bytes;
                    r_res_ecn    <= desc_rdata[1:0];
                    r_byte_cnt   <= (r_byte_cnt >= ByteW'(rd_bytes))
                                    ? r_byte_cnt - ByteW'(rd_bytes) : '0;
                    r_state      <= S_EVAL;
                end
                S_EVAL: begin
                    r_first_above <= e_fa;
                    r_res_inst    <= r_sojourn > TW'(r_inst_thr);
                    r_state       <= S_PUSH;
                    if (r_active) begin
                        if (!e_ok) begin
                            r_active <= 1'b0;
                        end else if (r_now >= r_next_mark) begin
                            r_mark_cnt <= e_cnt_inc;
                            r_res_pers <= 1'b1;
                            if (e_cnt_inc <= MW'(1)) begin
                                r_root  <= {1'b1, {MW{1'b0}}};
                                r_state <= S_MUL;
                            end else begin
                                r_sq_start <= 1'b1;
                                r_state    <= S_SQRT;
                            end
                        end
                    end else if (e_ok) begin
                        r_active    <= 1'b1;
                        r_mark_cnt  <= MW'(1);
                        r_next_mark <= e_sum_int;
                        r_res_pers  <= 1'b1;
                    end
                end
                S_SQRT: begin
                    if (sq_done) begin
                        r_root  <= {1'b0, sq_root};
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= 41'(r_interval) * 41'(r_root);
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_next_mark <= r_now + TW'(r_prod[40:16]);
                    r_state     <= S_PUSH;
                end
                S_PUSH: begin
                    // Move the staged result into the output register.
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_status      <= r_res_status;
                        r_handle_out  <= r_res_handle;
                        r_bytes_out   <= r_res_bytes;
                        r_ecn_out     <= ce ? ecsq_pkg::EcnCe : r_res_ecn;
                        r_sojourn_out <= r_sojourn;
                        r_inst_out    <= r_res_inst;
                        r_pers_out    <= r_res_pers;
                        r_ce_out      <= ce;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_handle_out      = r_handle_out;
    assign o_bytes_out       = r_bytes_out;
    assign o_ecn_out         = r_ecn_out;
    assign o_sojourn_ns      = r_sojourn_out;
    assign o_instant_mark    = r_inst_out;
    assign o_persistent_mark = r_pers_out;
    assign o_ce_applied      = r_ce_out;

endmodule

>>> rtl/core/ecsq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ecsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/ecsq_rsqrt.sv
// Bit-serial unit for floor(sqrt(2^32 / count)), one result bit per cycle.
module ecsq_rsqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ecsq_pkg::MarkW-1:0]  i_count,
    output logic                        o_done,
    output logic [ecsq_pkg::MarkW-1:0]  o_root
);

    // The root is the largest r with r*r*count <= 2^32. Squares are kept
    // incrementally: r*r*count in r_sq and r*count in r_rc.
    localparam logic [49:0] Limit = 50'h1_0000_0000;

    logic                       r_busy;
    logic                       r_done;
    logic [3:0]                 r_bit;
    logic [ecsq_pkg::MarkW-1:0] r_cnt;
    logic [ecsq_pkg::MarkW-1:0] r_root;
    logic [32:0]                r_sq;
    logic [31:0]                r_rc;
    logic [49:0]                cand;
    logic                       fits;

    // Trial square with the current bit set.
    always_comb begin
        cand = 50'(r_sq) + (50'(r_rc) << ({1'b0, r_bit} + 5'd1))
             + (50'(r_cnt) << {r_bit, 1'b0});
        fits = cand <= Limit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_bit  <= 4'd15;
                r_cnt  <= i_count;
                r_root <= '0;
                r_sq   <= '0;
                r_rc   <= '0;
            end else if (r_busy) begin
                if (fits) begin
                    r_root[r_bit] <= 1'b1;
                    r_sq          <= cand[32:0];
                    r_rc          <= r_rc + (32'(r_cnt) << r_bit);
                end
                if (r_bit == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_bit <= r_bit - 4'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

>>> verif/ecn_sojourn_marking_queue_unit_test.sv
// Self-checking testbench for the ECN sojourn marking queue unit.
module ecn_sojourn_marking_queue_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int Depth = ecsq_pkg::QueueDepthDefault;

    typedef struct packed {
        logic [1:0]                   status;
        logic [ecsq_pkg::HandleW-1:0] handle;
        logic [ecsq_pkg::BytesW-1:0]  bytes;
        logic [ecsq_pkg::EcnW-1:0]    ecn;
        logic [ecsq_pkg::TimeW-1:0]   sojourn;
        logic                         inst;
        logic                         pers;
        logic                         ce;
    } t_outcome;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic                         i_command;
    logic [ecsq_pkg::TimeW-1:0]   i_now_ns;
    logic [ecsq_pkg::BytesW-1:0]  i_packet_bytes;
    logic [ecsq_pkg::EcnW-1:0]    i_ecn_in;
    logic [ecsq_pkg::HandleW-1:0] i_packet_handle;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic [1:0]                   o_status;
    logic [ecsq_pkg::HandleW-1:0] o_handle_out;
    logic [ecsq_pkg::BytesW-1:0]  o_bytes_out;
    logic [ecsq_pkg::EcnW-1:0]    o_ecn_out;
    logic [ecsq_pkg::TimeW-1:0]   o_sojourn_ns;
    logic                         o_instant_mark;
    logic                         o_persistent_mark;
    logic                         o_ce_applied;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [ecsq_pkg::CfgIdxW-1:0] i_cfg_index;
    logic [ecsq_pkg::RegW-1:0]    i_cfg_data;

    ecn_sojourn_marking_queue_unit #(.QUEUE_DEPTH(Depth)) dut (.*);

    // Shadow configuration and queue state.
    logic                         by_packets;
    logic [ecsq_pkg::MaxPktW-1:0] pkt_limit;
    logic [ecsq_pkg::RegW-1:0]    byte_limit;
    logic [ecsq_pkg::RegW-1:0]    inst_thresh;
    logic [ecsq_pkg::RegW-1:0]    interval;
    logic [ecsq_pkg::RegW-1:0]    target;
    logic [ecsq_pkg::TimeW-1:0]   arrivals[$];
    logic [ecsq_pkg::DescW-1:0]   descs[$];
    logic [25:0]                  queued_bytes;
    logic [ecsq_pkg::TimeW-1:0]   above_deadline;
    logic                         marking;
    logic [ecsq_pkg::TimeW-1:0]   next_mark;
    logic [ecsq_pkg::MarkW-1:0]   mark_count;

    t_outcome                     pending[$];
    int                           mismatches;
    logic [ecsq_pkg::TimeW-1:0]   clock_ns;
    bit                           long_hold;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("ecn_sojourn_marking_queue_unit_test failed");
        $finish;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        mismatches++;
    endtask

    // Integer square root by bit pairs.
    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 40;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // Next mark spacing: interval / sqrt(count), using a truncated Q0.16 reciprocal root.
    function automatic logic [63:0] mark_spacing();
        logic [63:0] r;
        if (mark_count <= 1) return interval;
        r = isqrt((64'd1 << 32) / mark_count);
        return (64'(interval) * r) >> 16;
    endfunction

    function automatic t_outcome predict_word(input logic cmd,
                                              input logic [ecsq_pkg::TimeW-1:0] now,
                                              input logic [ecsq_pkg::BytesW-1:0] len,
                                              input logic [ecsq_pkg::EcnW-1:0] cp,
                                              input logic [ecsq_pkg::HandleW-1:0] hdl);
        t_outcome o;
        logic drop;
        logic [ecsq_pkg::TimeW-1:0] arr;
        logic [ecsq_pkg::DescW-1:0] d;
        logic [ecsq_pkg::BytesW-1:0] blen;
        logic ok;
        o = '0;
        if (cmd == ecsq_pkg::CmdEnqueue) begin
            drop = descs.size() >= Depth;
            if (by_packets) begin
                if (descs.size() + 1 > pkt_limit) drop = 1'b1;
            end else if (64'(queued_bytes) + 64'(len) > 64'(byte_limit)) begin
                drop = 1'b1;
            end
            if (drop) begin
                o.status = ecsq_pkg::StatusDropped;
            end else begin
                arrivals.push_back(now);
                descs.push_back({hdl, len, cp});
                queued_bytes += len;
                o.status = ecsq_pkg::StatusAccepted;
            end
            return o;
        end
        if (descs.size() == 0) begin
            o.status = ecsq_pkg::StatusEmpty;
            return o;
        end
        arr = arrivals.pop_front();
        d = descs.pop_front();
        blen = d[17:2];
        queued_bytes -= (queued_bytes >= blen) ? blen : queued_bytes;
        o.status = ecsq_pkg::StatusDelivered;
        o.handle = d[33:18];
        o.bytes = blen;
        o.ecn = d[1:0];
        o.sojourn = (now >= arr) ? now - arr : '0;
        o.inst = o.sojourn > inst_thresh;
        // Persistent condition: above target for a full interval.
        ok = 1'b0;
        if (o.sojourn < target) begin
            above_deadline = '0;
        end else if (above_deadline == 0) begin
            above_deadline = now + interval;
        end else if (now > above_deadline) begin
            ok = 1'b1;
        end
        if (marking) begin
            if (!ok) begin
                marking = 1'b0;
            end else if (now >= next_mark) begin
                if (mark_count != 16'hFFFF) mark_count++;
                next_mark = now + ecsq_pkg::TimeW'(mark_spacing());
                o.pers = 1'b1;
            end
        end else if (ok) begin
            marking = 1'b1;
            mark_count = 1;
            next_mark = now + interval;
            o.pers = 1'b1;
        end
        if ((o.inst || o.pers) && o.ecn == ecsq_pkg::EcnEct1) begin
            o.ecn = ecsq_pkg::EcnCe;
            o.ce = 1'b1;
        end
        return o;
    endfunction

    // Result checker; the receiver waits a random number of cycles after each word.
    initial begin
        int wait_cycles;
        t_outcome w;
        t_outcome e;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            wait_cycles = 0;
            if (o_out_valid && !i_out_stall && i_rst_n) begin
                w = {o_status, o_handle_out, o_bytes_out, o_ecn_out, o_sojourn_ns,
                     o_instant_mark, o_persistent_mark, o_ce_applied};
                if (pending.size() == 0) begin
                    report("unexpected word", w.status, 0);
                end else begin
                    e = pending.pop_front();
                    if (w.status != e.status) report("status", w.status, e.status);
                    if (w.handle != e.handle) report("handle", w.handle, e.handle);
                    if (w.bytes != e.bytes) report("bytes", w.bytes, e.bytes);
                    if (w.ecn != e.ecn) report("ecn", w.ecn, e.ecn);
                    if (w.sojourn != e.sojourn) report("sojourn", w.sojourn, e.sojourn);
                    if (w.inst != e.inst) report("instant", w.inst, e.inst);
                    if (w.pers != e.pers) report("persistent", w.pers, e.pers);
                    if (w.ce != e.ce) report("ce", w.ce, e.ce);
                end
                wait_cycles = $urandom_range(0, 8);
            end
            if (long_hold) begin
                i_out_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                long_hold = 1'b0;
                i_out_stall <= 1'b0;
            end else if (wait_cycles != 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Sends one command word after a random gap; valid stays high when there is no gap.
    task automatic send_word(input logic cmd, input logic [ecsq_pkg::TimeW-1:0] now,
                             input logic [ecsq_pkg::BytesW-1:0] len,
                             input logic [ecsq_pkg::EcnW-1:0] cp,
                             input logic [ecsq_pkg::HandleW-1:0] hdl, input bit gaps = 1);
        int gap;
        gap = gaps ? $urandom_range(0, 8) : 0;
        if ($urandom_range(0, 2) == 0) gap = 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_now_ns <= now;
        i_packet_bytes <= len;
        i_ecn_in <= cp;
        i_packet_handle <= hdl;
        do @(posedge i_clk); while (o_in_stall);
        pending.push_back(predict_word(cmd, now, len, cp, hdl));
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (pending.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [ecsq_pkg::CfgIdxW-1:0] idx,
                             input logic [ecsq_pkg::RegW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            ecsq_pkg::CfgLimitByPackets: by_packets = val[0];
            ecsq_pkg::CfgMaxPackets:     pkt_limit = val[ecsq_pkg::MaxPktW-1:0];
            ecsq_pkg::CfgMaxBytes:       byte_limit = val;
            ecsq_pkg::CfgInstThreshold:  inst_thresh = val;
            ecsq_pkg::CfgInterval:       interval = val;
            ecsq_pkg::CfgTarget:         target = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic logic [ecsq_pkg::TimeW-1:0] tick(input int unsigned lo,
                                                       input int unsigned hi);
        clock_ns += $urandom_range(lo, hi);
        return clock_ns;
    endfunction

    // Empty dequeues, extreme fields and codepoints.
    task automatic test_directed();
        send_word(ecsq_pkg::CmdDequeue, 48'd5, 0, 0, 0);
        send_word(ecsq_pkg::CmdEnqueue, 48'd10, 16'hFFFF, 2'd1, 16'hFFFF);
        send_word(ecsq_pkg::CmdEnqueue, 48'd10, 16'd0, 2'd0, 16'd0);
        send_word(ecsq_pkg::CmdEnqueue, 48'd20, 16'h5555, 2'd2, 16'hAAAA);
        send_word(ecsq_pkg::CmdEnqueue, 48'd20, 16'hAAAA, 2'd3, 16'h5555);
        send_word(ecsq_pkg::CmdEnqueue, 48'd30, 16'd100, 2'd1, 16'd7);
        send_word(ecsq_pkg::CmdEnqueue, 48'd30, 16'hFFFF, 2'd1, 16'd8);
        send_word(ecsq_pkg::CmdEnqueue, 48'd30, 16'hFFFF, 2'd1, 16'd9);
        // Instant mark, and time running backwards.
        send_word(ecsq_pkg::CmdDequeue, 48'd30000, 0, 0, 0);
        send_word(ecsq_pkg::CmdDequeue, 48'd5, 0, 0, 0);
        send_word(ecsq_pkg::CmdDequeue, 48'hFFFF_FFFF_FFFF, 0, 0, 0);
        send_word(ecsq_pkg::CmdDequeue, 48'd200000, 0, 0, 0);
        send_word(ecsq_pkg::CmdDequeue, 48'd400000, 0, 0, 0);
        send_word(ecsq_pkg::CmdDequeue, 48'd400001, 0, 0, 0);
        send_word(ecsq_pkg::CmdDequeue, 48'd400002, 0, 0, 0);
        drain();
    endtask

    // Packet mode, zero packet limit, and a full block under a long receiver hold.
    task automatic test_limits();
        write_reg(ecsq_pkg::CfgLimitByPackets, 24'd1);
        write_reg(ecsq_pkg::CfgMaxPackets, 24'd0);
        send_word(ecsq_pkg::CmdEnqueue, 48'd1, 16'd1, 2'd1, 16'd1);
        drain();
        write_reg(ecsq_pkg::CfgMaxPackets, 24'd3);
        repeat (5) send_word(ecsq_pkg::CmdEnqueue, tick(1, 9), 16'd60, 2'd1, 16'($urandom));
        // Switch to bytes with packets still queued.
        drain();
        write_reg(ecsq_pkg::CfgLimitByPackets, 24'd0);
        write_reg(ecsq_pkg::CfgMaxBytes, 24'd1);
        send_word(ecsq_pkg::CmdEnqueue, tick(1, 9), 16'd1, 2'd1, 16'd3);
        repeat (5) send_word(ecsq_pkg::CmdDequeue, tick(1, 9), 0, 0, 0);
        drain();
        write_reg(ecsq_pkg::CfgLimitByPackets, 24'd1);
        write_reg(ecsq_pkg::CfgMaxPackets, 24'd1024);
        long_hold = 1'b1;
        repeat (40) send_word(ecsq_pkg::CmdEnqueue, tick(0, 3), 16'($urandom), 2'($urandom),
                              16'($urandom), 0);
        repeat (36) send_word(ecsq_pkg::CmdDequeue, tick(0, 3), 0, 0, 0, 0);
        drain();
    endtask

    // Long persistent episodes with counter growth, deadline wrap near 2^48.
    task automatic test_persistent();
        logic [ecsq_pkg::TimeW-1:0] t;
        write_reg(ecsq_pkg::CfgLimitByPackets, 24'd0);
        write_reg(ecsq_pkg::CfgMaxBytes, 24'hFFFFFF);
        write_reg(ecsq_pkg::CfgInstThreshold, 24'hFFFFFF);
        write_reg(ecsq_pkg::CfgInterval, 24'd1);
        write_reg(ecsq_pkg::CfgTarget, 24'd0);
        // Deadline arithmetic that wraps to exactly zero.
        send_word(ecsq_pkg::CmdEnqueue, 48'hFFFF_FFFF_FFFE, 16'd1, 2'd1, 16'd1);
        send_word(ecsq_pkg::CmdDequeue, 48'hFFFF_FFFF_FFFF, 0, 0, 0);
        send_word(ecsq_pkg::CmdEnqueue, 48'd0, 16'd1, 2'd1, 16'd2);
        send_word(ecsq_pkg::CmdDequeue, 48'd0, 0, 0, 0);
        drain();
        write_reg(ecsq_pkg::CfgInterval, 24'd1000);
        write_reg(ecsq_pkg::CfgTarget, 24'd50);
        t = 48'd1000000;
        for (int i = 0; i < 40; i++) begin
            t += 30;
            send_word(ecsq_pkg::CmdEnqueue, t, 16'd64, 2'($urandom), 16'(i));
            t += $urandom_range(60, 400);
            send_word(ecsq_pkg::CmdDequeue, t, 0, 0, 0);
        end
        drain();
        write_reg(ecsq_pkg::CfgInterval, 24'hFFFFFF);
        write_reg(ecsq_pkg::CfgTarget, 24'hFFFFFF);
        send_word(ecsq_pkg::CmdEnqueue, 48'd0, 16'd1, 2'd1, 16'd5);
        send_word(ecsq_pkg::CmdDequeue, 48'h1000000, 0, 0, 0);
        send_word(ecsq_pkg::CmdEnqueue, 48'd0, 16'd1, 2'd1, 16'd6);
        send_word(ecsq_pkg::CmdDequeue, 48'h3000000, 0, 0, 0);
        drain();
    endtask

    // Random traffic under several settings.
    task automatic test_random();
        for (int phase = 0; phase < 3; phase++) begin
            write_reg(ecsq_pkg::CfgLimitByPackets, 24'($urandom_range(0, 1)));
            write_reg(ecsq_pkg::CfgMaxPackets, 24'($urandom_range(1, 40)));
            write_reg(ecsq_pkg::CfgMaxBytes, 24'($urandom_range(1000, 400000)));
            write_reg(ecsq_pkg::CfgInstThreshold, 24'($urandom_range(0, 3000)));
            write_reg(ecsq_pkg::CfgInterval, 24'($urandom_range(1, 2000)));
            write_reg(ecsq_pkg::CfgTarget, 24'($urandom_range(0, 800)));
            for (int i = 0; i < 100; i++) begin
                if ($urandom_range(0, 1))
                    send_word(ecsq_pkg::CmdEnqueue, tick(0, 400), 16'($urandom),
                              2'($urandom), 16'($urandom));
                else
                    send_word(ecsq_pkg::CmdDequeue, tick(0, 400), 0, 0, 0);
            end
            drain();
        end
    endtask

    initial begin
        mismatches = 0;
        long_hold = 1'b0;
        clock_ns = 48'd5000000;
        by_packets = 1'b0;
        pkt_limit = ecsq_pkg::RstMaxPackets;
        byte_limit = ecsq_pkg::RstMaxBytes;
        inst_thresh = ecsq_pkg::RstInstThreshold;
        interval = ecsq_pkg::RstInterval;
        target = ecsq_pkg::RstTarget;
        queued_bytes = '0;
        above_deadline = '0;
        marking = 1'b0;
        next_mark = '0;
        mark_count = '0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_command <= ecsq_pkg::CmdEnqueue;
        i_now_ns <= '0;
        i_packet_bytes <= '0;
        i_ecn_in <= '0;
        i_packet_handle <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= ecsq_pkg::CfgLimitByPackets;
        i_cfg_data <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_limits();
        test_persistent();
        test_random();
        if (pending.size() != 0) begin
            report("words still expected", pending.size(), 0);
        end
        if (mismatches == 0) begin
            $display("ecn_sojourn_marking_queue_unit_test passed");
        end else begin
            $display("ecn_sojourn_marking_queue_unit_test failed");
        end
        $finish;
    end
endmodule
